>>> design/ctsc_pkg.sv
`default_nettype none

package ctsc_pkg;

	// Field widths
	localparam int unsigned SEC_W   = 6;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned WDAY_W  = 3;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 7;
	localparam int unsigned CUR_W   = 3;
	localparam int unsigned FIELD_W = 7;   // widest time field

	// Input word: time fields, lowest bit first
	localparam int unsigned TIME_BITS = SEC_W + MIN_W + HOUR_W + WDAY_W + DAY_W + MONTH_W + YEAR_W;
	localparam int unsigned S_DATA_W  = ((TIME_BITS + 7) / 8) * 8;
	localparam int unsigned S_USER_W  = 3;

	// Output word: cursor, editing, alarm_mode, ringing, then the time fields
	localparam int unsigned M_BITS    = CUR_W + 3 + TIME_BITS;
	localparam int unsigned M_DATA_W  = ((M_BITS + 7) / 8) * 8;
	localparam int unsigned M_USER_W  = 2;

	typedef enum logic [S_USER_W-1:0] {
		CMD_SELECT   = 3'd0,
		CMD_UP       = 3'd1,
		CMD_DOWN     = 3'd2,
		CMD_ALARM    = 3'd3,
		CMD_SNAPSHOT = 3'd4,
		CMD_ALARM_IRQ = 3'd5
	} cmd_t;

	typedef enum logic [M_USER_W-1:0] {
		COMMIT_NONE  = 2'd0,
		COMMIT_TIME  = 2'd1,
		COMMIT_ALARM = 2'd2
	} commit_t;

	// Cursor positions
	localparam logic [CUR_W-1:0] CUR_OFF   = 3'd0;
	localparam logic [CUR_W-1:0] CUR_SEC   = 3'd1;
	localparam logic [CUR_W-1:0] CUR_MIN   = 3'd2;
	localparam logic [CUR_W-1:0] CUR_HOUR  = 3'd3;
	localparam logic [CUR_W-1:0] CUR_WDAY  = 3'd4;
	localparam logic [CUR_W-1:0] CUR_DAY   = 3'd5;
	localparam logic [CUR_W-1:0] CUR_MONTH = 3'd6;
	localparam logic [CUR_W-1:0] CUR_YEAR  = 3'd7;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [WDAY_W-1:0]  weekday;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   min;
		logic [SEC_W-1:0]   sec;
	} time_t;

	typedef struct packed {
		logic [CUR_W-1:0] cursor;
		logic             editing;
		logic             alarm_mode;
		logic             ringing;
	} status_t;

	// Lower bound of the field under the cursor
	function automatic logic [FIELD_W-1:0] field_min(input logic [CUR_W-1:0] pos);
		logic [FIELD_W-1:0] v;
		unique case (pos)
			CUR_WDAY, CUR_DAY, CUR_MONTH: v = 7'd1;
			default:                      v = 7'd0;
		endcase
		return v;
	endfunction

	// Upper bound of the field under the cursor
	function automatic logic [FIELD_W-1:0] field_max(input logic [CUR_W-1:0] pos);
		logic [FIELD_W-1:0] v;
		unique case (pos)
			CUR_SEC, CUR_MIN: v = 7'd59;
			CUR_HOUR:         v = 7'd23;
			CUR_WDAY:         v = 7'd7;
			CUR_DAY:          v = 7'd31;
			CUR_MONTH:        v = 7'd12;
			CUR_YEAR:         v = 7'd99;
			default:          v = 7'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> design/clock_time_set_controller.sv
`default_nettype none

// Clock setting controller. Each input word is one event (tuser: select, up,
// down, alarm key, time snapshot, alarm interrupt) and yields exactly one
// output word with the commit request and the full status and time fields
// after that event. A word moves through an input register and a result
// register, in that order, and the result word is taken from the result
// register when the output side is ready. One word is taken in every cycle
// while the output is not stalled; the update of the cursor, flags and field
// registers sets that rate, and a stalled output holds the input register.
// Reset loads the time 15:34:00, weekday 5, day 20, month 5, year 11, with
// no edit, no alarm mode and no ringing.
module clock_time_set_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// sec_in, min_in, hour_in, weekday_in, day_in, month_in, year_in, zero pad
	input  wire logic [ctsc_pkg::S_DATA_W-1:0]   s_tdata,
	// command
	input  wire logic [ctsc_pkg::S_USER_W-1:0]   s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// cursor, editing, alarm_mode, ringing, sec_out, min_out, hour_out,
	// weekday_out, day_out, month_out, year_out, zero pad
	output logic [ctsc_pkg::M_DATA_W-1:0]        m_tdata,
	// commit
	output logic [ctsc_pkg::M_USER_W-1:0]        m_tuser
);
	import ctsc_pkg::*;

	// Input register
	logic                valid_s1;
	time_t               time_s1;
	logic [S_USER_W-1:0] cmd_s1;

	// Controller state
	status_t stat_q, stat_d;
	time_t   time_q, time_d;
	commit_t commit_d;

	// Result register
	logic    valid_s2;
	status_t stat_s2;
	time_t   time_s2;
	commit_t commit_s2;

	logic advance;
	logic is_key;
	logic [CUR_W:0]     sel_sum;
	logic [FIELD_W-1:0] fld_cur, fld_new, fld_lo, fld_hi;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Capture an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			time_s1 <= time_t'(s_tdata[TIME_BITS-1:0]);
			cmd_s1  <= s_tuser;
		end
	end

	// Pick the field under the cursor and wrap it up or down
	always_comb begin
		unique case (stat_q.cursor)
			CUR_SEC:   fld_cur = {1'b0, time_q.sec};
			CUR_MIN:   fld_cur = {1'b0, time_q.min};
			CUR_HOUR:  fld_cur = {2'b0, time_q.hour};
			CUR_WDAY:  fld_cur = {4'b0, time_q.weekday};
			CUR_DAY:   fld_cur = {2'b0, time_q.day};
			CUR_MONTH: fld_cur = {3'b0, time_q.month};
			CUR_YEAR:  fld_cur = time_q.year;
			default:   fld_cur = '0;
		endcase
		fld_lo = field_min(stat_q.cursor);
		fld_hi = field_max(stat_q.cursor);
		if (cmd_s1 == CMD_UP) begin
			fld_new = (fld_cur >= fld_hi) ? fld_lo : fld_cur + 7'd1;
		end else begin
			fld_new = (fld_cur <= fld_lo) ? fld_hi : fld_cur - 7'd1;
		end
	end

	// Next state for one event
	always_comb begin
		stat_d   = stat_q;
		time_d   = time_q;
		commit_d = COMMIT_NONE;
		is_key   = (cmd_s1 == CMD_SELECT) || (cmd_s1 == CMD_UP) ||
		           (cmd_s1 == CMD_DOWN) || (cmd_s1 == CMD_ALARM);
		sel_sum  = {1'b0, stat_q.cursor} + 4'd1;
		if (is_key && stat_q.ringing) begin
			stat_d.ringing = 1'b0;
		end else begin
			case (cmd_s1)
				CMD_SELECT: begin
					stat_d.editing = 1'b1;
					if (stat_q.alarm_mode && sel_sum > {1'b0, CUR_HOUR}) begin
						stat_d.cursor = CUR_SEC;
					end else if (sel_sum[CUR_W]) begin
						stat_d.cursor  = CUR_OFF;
						stat_d.editing = 1'b0;
						commit_d       = COMMIT_TIME;
					end else begin
						stat_d.cursor = sel_sum[CUR_W-1:0];
					end
				end
				CMD_UP, CMD_DOWN: begin
					unique case (stat_q.cursor)
						CUR_SEC:   time_d.sec     = fld_new[SEC_W-1:0];
						CUR_MIN:   time_d.min     = fld_new[MIN_W-1:0];
						CUR_HOUR:  time_d.hour    = fld_new[HOUR_W-1:0];
						CUR_WDAY:  time_d.weekday = fld_new[WDAY_W-1:0];
						CUR_DAY:   time_d.day     = fld_new[DAY_W-1:0];
						CUR_MONTH: time_d.month   = fld_new[MONTH_W-1:0];
						CUR_YEAR:  time_d.year    = fld_new[YEAR_W-1:0];
						default:   time_d         = time_q;
					endcase
				end
				CMD_ALARM: begin
					stat_d.alarm_mode = !stat_q.alarm_mode;
					if (stat_q.alarm_mode) begin
						stat_d.editing = 1'b0;
						stat_d.cursor  = CUR_OFF;
						commit_d       = COMMIT_ALARM;
					end else begin
						time_d.sec  = time_s1.sec;
						time_d.min  = time_s1.min;
						time_d.hour = time_s1.hour;
					end
				end
				CMD_SNAPSHOT: begin
					if (!stat_q.editing && !stat_q.alarm_mode) begin
						time_d = time_s1;
					end
				end
				CMD_ALARM_IRQ: begin
					stat_d.ringing = 1'b1;
				end
				default: begin
					stat_d = stat_q;
				end
			endcase
		end
	end

	// Advance state and result together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q       <= '0;
			time_q.sec   <= 6'd0;
			time_q.min   <= 6'd34;
			time_q.hour  <= 5'd15;
			time_q.weekday <= 3'd5;
			time_q.day   <= 5'd20;
			time_q.month <= 4'd5;
			time_q.year  <= 7'd11;
			valid_s2     <= 1'b0;
		end else begin
			if (advance) begin
				stat_q <= stat_d;
				time_q <= time_d;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stat_s2   <= stat_d;
			time_s2   <= time_d;
			commit_s2 <= commit_d;
		end
	end

	// Drive the output word
	assign m_tvalid = valid_s2;
	assign m_tuser  = commit_s2;
	assign m_tdata  = {{(M_DATA_W - M_BITS){1'b0}}, time_s2,
	                   stat_s2.ringing, stat_s2.alarm_mode, stat_s2.editing, stat_s2.cursor};

	// Cursor is nonzero exactly while a field is being edited
	a_edit_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		stat_q.editing == (stat_q.cursor != CUR_OFF))
		else $error("edit flag and cursor disagree");

	// A commit never comes out while the alarm rings
	a_commit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && commit_s2 != COMMIT_NONE |-> !stat_s2.ringing && stat_s2.cursor == CUR_OFF)
		else $error("commit with ringing or open cursor");

	// A stalled input word is kept
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cmd_s1) && $stable(time_s1))
		else $error("input register lost a stalled word");

	// Leaving alarm mode closes the editor
	a_alarm_exit: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(stat_q.alarm_mode) |-> stat_q.cursor == CUR_OFF && !stat_q.editing)
		else $error("alarm exit left the editor open");

endmodule

`default_nettype wire

>>> dv/tb_clock_time_set_controller.sv
`default_nettype none

module tb_clock_time_set_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import ctsc_pkg::*;

	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned PHASE_EVENTS = 180;
	localparam int unsigned MAX_PRINTS = 60;
	localparam logic [S_USER_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [S_USER_W-1:0] CMD_SPARE_HI = 3'd7;

	// One input word: the command and the time fields it carries
	typedef struct packed {
		logic [S_USER_W-1:0] cmd;
		time_t               t;
	} key_event_t;

	// One output word: commit request, status and the displayed fields
	typedef struct packed {
		logic [M_USER_W-1:0] commit;
		logic [CUR_W-1:0]    cursor;
		logic                editing;
		logic                alarm_mode;
		logic                ringing;
		time_t               t;
	} clock_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [S_USER_W-1:0] s_tuser = '0;
	logic m_tready = 1'b0;
	wire logic s_tready;
	wire logic m_tvalid;
	wire logic [M_DATA_W-1:0] m_tdata;
	wire logic [M_USER_W-1:0] m_tuser;

	key_event_t pending_events[$];
	clock_view_t expected_views[$];
	key_event_t in_flight;
	clock_view_t clock_now;
	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	clock_time_set_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic time_t make_time(input int sec, input int min, input int hour,
			input int wday, input int day, input int month, input int year);
		time_t t;
		t.sec = SEC_W'(sec);
		t.min = MIN_W'(min);
		t.hour = HOUR_W'(hour);
		t.weekday = WDAY_W'(wday);
		t.day = DAY_W'(day);
		t.month = MONTH_W'(month);
		t.year = YEAR_W'(year);
		return t;
	endfunction

	function automatic clock_view_t reset_view();
		clock_view_t v;
		v.commit = COMMIT_NONE;
		v.cursor = CUR_OFF;
		v.editing = 1'b0;
		v.alarm_mode = 1'b0;
		v.ringing = 1'b0;
		v.t = make_time(0, 34, 15, 5, 20, 5, 11);
		return v;
	endfunction

	// Field under the cursor, zero-extended
	function automatic logic [FIELD_W-1:0] field_of(input time_t t, input logic [CUR_W-1:0] pos);
		logic [FIELD_W-1:0] f;
		f = '0;
		case (pos)
			CUR_SEC:   f = FIELD_W'(t.sec);
			CUR_MIN:   f = FIELD_W'(t.min);
			CUR_HOUR:  f = FIELD_W'(t.hour);
			CUR_WDAY:  f = FIELD_W'(t.weekday);
			CUR_DAY:   f = FIELD_W'(t.day);
			CUR_MONTH: f = FIELD_W'(t.month);
			CUR_YEAR:  f = t.year;
			default:   f = '0;
		endcase
		return f;
	endfunction

	function automatic time_t with_field(input time_t t, input logic [CUR_W-1:0] pos,
			input logic [FIELD_W-1:0] f);
		time_t n;
		n = t;
		case (pos)
			CUR_SEC:   n.sec = f[SEC_W-1:0];
			CUR_MIN:   n.min = f[MIN_W-1:0];
			CUR_HOUR:  n.hour = f[HOUR_W-1:0];
			CUR_WDAY:  n.weekday = f[WDAY_W-1:0];
			CUR_DAY:   n.day = f[DAY_W-1:0];
			CUR_MONTH: n.month = f[MONTH_W-1:0];
			CUR_YEAR:  n.year = f;
			default:   n = t;
		endcase
		return n;
	endfunction

	function automatic logic [FIELD_W-1:0] wrap_low(input logic [CUR_W-1:0] pos);
		case (pos)
			CUR_WDAY, CUR_DAY, CUR_MONTH: return 7'd1;
			default:                      return 7'd0;
		endcase
	endfunction

	function automatic logic [FIELD_W-1:0] wrap_high(input logic [CUR_W-1:0] pos);
		case (pos)
			CUR_SEC, CUR_MIN: return 7'd59;
			CUR_HOUR:         return 7'd23;
			CUR_WDAY:         return 7'd7;
			CUR_DAY:          return 7'd31;
			CUR_MONTH:        return 7'd12;
			CUR_YEAR:         return 7'd99;
			default:          return 7'd0;
		endcase
	endfunction

	// Advance the clock settings by one event and give the word it produces
	function automatic clock_view_t clock_next(input clock_view_t v, input key_event_t ev);
		clock_view_t n;
		logic [CUR_W:0] cur;
		logic [FIELD_W-1:0] f;
		n = v;
		n.commit = COMMIT_NONE;
		if (ev.cmd <= CMD_ALARM && v.ringing) begin
			// any key only silences the alarm
			n.ringing = 1'b0;
		end else begin
			case (ev.cmd)
				CMD_SELECT: begin
					cur = {1'b0, v.cursor} + 1'b1;
					if (v.alarm_mode && cur > CUR_HOUR)
						cur = {1'b0, CUR_SEC};
					n.editing = 1'b1;
					if (cur > CUR_YEAR) begin
						cur = '0;
						n.editing = 1'b0;
						n.commit = COMMIT_TIME;
					end
					n.cursor = cur[CUR_W-1:0];
				end
				CMD_UP, CMD_DOWN: begin
					if (v.cursor != CUR_OFF) begin
						f = field_of(v.t, v.cursor);
						if (ev.cmd == CMD_UP)
							f = (f >= wrap_high(v.cursor)) ? wrap_low(v.cursor) : f + 1'b1;
						else
							f = (f <= wrap_low(v.cursor)) ? wrap_high(v.cursor) : f - 1'b1;
						n.t = with_field(v.t, v.cursor, f);
					end
				end
				CMD_ALARM: begin
					n.alarm_mode = !v.alarm_mode;
					if (!n.alarm_mode) begin
						n.editing = 1'b0;
						n.cursor = CUR_OFF;
						n.commit = COMMIT_ALARM;
					end else begin
						n.t.sec = ev.t.sec;
						n.t.min = ev.t.min;
						n.t.hour = ev.t.hour;
					end
				end
				CMD_SNAPSHOT: begin
					if (!v.editing && !v.alarm_mode)
						n.t = ev.t;
				end
				CMD_ALARM_IRQ: n.ringing = 1'b1;
				default: ;
			endcase
		end
		return n;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTS)
			$display("[%0t] MISMATCH %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
	endtask

	// Drive input words from the pending queue; predict each accepted word
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			clock_now = reset_view();
		end else begin
			if (s_tvalid && s_tready) begin
				clock_now = clock_next(clock_now, in_flight);
				expected_views.push_back(clock_now);
			end
			if (s_tvalid && !s_tready) begin
				// hold the word until taken
			end else if (pending_events.size() > 0 && $urandom_range(99) >= idle_pct) begin
				in_flight = pending_events.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {{(S_DATA_W - TIME_BITS){1'b0}}, in_flight.t};
				s_tuser <= in_flight.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Stall the output side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Compare each output word with the oldest prediction
	always @(posedge clk) begin
		clock_view_t want;
		time_t got_t;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_views.size() == 0) begin
				report_mismatch($sformatf("output word with none expected: user %0d data %h",
					m_tuser, m_tdata));
			end else begin
				want = expected_views.pop_front();
				got_t = m_tdata[CUR_W+3 +: TIME_BITS];
				check_field("commit", m_tuser, want.commit);
				check_field("cursor", m_tdata[CUR_W-1:0], want.cursor);
				check_field("editing", m_tdata[CUR_W], want.editing);
				check_field("alarm_mode", m_tdata[CUR_W+1], want.alarm_mode);
				check_field("ringing", m_tdata[CUR_W+2], want.ringing);
				check_field("sec_out", got_t.sec, want.t.sec);
				check_field("min_out", got_t.min, want.t.min);
				check_field("hour_out", got_t.hour, want.t.hour);
				check_field("weekday_out", got_t.weekday, want.t.weekday);
				check_field("day_out", got_t.day, want.t.day);
				check_field("month_out", got_t.month, want.t.month);
				check_field("year_out", got_t.year, want.t.year);
			end
		end
	end

	// Abort when no word moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
				$display("clock_time_set_controller test failed");
				$finish;
			end
		end
	end

	// Events queued in the current phase
	int phase_items;

	function automatic time_t random_time();
		if ($urandom_range(9) == 0)
			return time_t'(TIME_BITS'({$urandom, $urandom}));
		return make_time($urandom_range(59), $urandom_range(59), $urandom_range(23),
			$urandom_range(7, 1), $urandom_range(31, 1), $urandom_range(12, 1),
			$urandom_range(99));
	endfunction

	task automatic add_event(input logic [S_USER_W-1:0] cmd, input time_t t);
		key_event_t ev;
		ev.cmd = cmd;
		ev.t = t;
		pending_events.push_back(ev);
		phase_items++;
	endtask

	task automatic add_random_burst();
		logic [S_USER_W-1:0] cmd;
		int r;
		int reps;
		r = $urandom_range(99);
		reps = 1;
		if (r < 24)
			cmd = CMD_SELECT;
		else if (r < 46)
			cmd = CMD_UP;
		else if (r < 64)
			cmd = CMD_DOWN;
		else if (r < 72)
			cmd = CMD_ALARM;
		else if (r < 88)
			cmd = CMD_SNAPSHOT;
		else if (r < 96)
			cmd = CMD_ALARM_IRQ;
		else
			cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
		// run up or down far enough to wrap a field
		if ((cmd == CMD_UP || cmd == CMD_DOWN) && $urandom_range(4) == 0)
			reps = $urandom_range(70, 2);
		repeat (reps) add_event(cmd, random_time());
	endtask

	// Wait until every word has gone out and been checked
	task automatic wait_drained();
		while (pending_events.size() > 0 || s_tvalid || expected_views.size() > 0)
			@(negedge clk);
	endtask

	initial begin
		time_t top_t;
		phase_items = 0;
		top_t = make_time(59, 59, 23, 7, 31, 12, 99);

		// Walk the cursor through every field with wraps at the limits
		add_event(CMD_UP, random_time());
		add_event(CMD_SNAPSHOT, top_t);
		add_event(CMD_SELECT, random_time());
		add_event(CMD_UP, random_time());
		add_event(CMD_DOWN, random_time());
		repeat (3) add_event(CMD_SELECT, random_time());
		add_event(CMD_UP, random_time());
		repeat (3) add_event(CMD_SELECT, random_time());
		add_event(CMD_UP, random_time());
		add_event(CMD_SELECT, random_time());
		// Snapshots with out-of-range and all-zero fields
		add_event(CMD_SNAPSHOT, '1);
		add_event(CMD_SNAPSHOT, '0);
		// Alarm mode: load, ignored snapshot, ring and silence, cursor wrap, leave
		add_event(CMD_ALARM, top_t);
		add_event(CMD_SNAPSHOT, random_time());
		add_event(CMD_ALARM_IRQ, random_time());
		add_event(CMD_SELECT, random_time());
		repeat (4) add_event(CMD_SELECT, random_time());
		add_event(CMD_ALARM, random_time());
		add_event(CMD_SPARE_LO, '1);
		add_event(CMD_SPARE_HI, '1);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 53; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 53; end
				default: begin idle_pct = 19; stall_pct = 19; end
			endcase
			phase_items = 0;
			while (phase_items < PHASE_EVENTS)
				add_random_burst();
			// hold off the next phase until all results are in
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("clock_time_set_controller test passed");
		else
			$display("clock_time_set_controller test failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> clock_time_set_controller.f
design/ctsc_pkg.sv
design/clock_time_set_controller.sv
dv/tb_clock_time_set_controller.sv
